@@ rtl/eight_bit_mcu_alu_regfile_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the eight-bit MCU ALU
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_MCU_ALU_REGFILE_MACROS_SVH
`define EIGHT_BIT_MCU_ALU_REGFILE_MACROS_SVH

// same-cycle implication
`define MCU_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mcu alu assertion failed");

// next-cycle implication
`define MCU_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mcu alu assertion failed");

`endif

@@ rtl/mcualu_pkg.sv @@
// ----------------------------------------------------------------------------
// mcualu_pkg
// Sizes, instruction codes and status flag masks of the eight-bit MCU ALU.
// ----------------------------------------------------------------------------
package mcualu_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int ROW_COUNT = REG_COUNT / 2;
    localparam int ROW_W     = REG_IDX_W - 1;

    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,
        OP_ADC    = 5'd1,
        OP_ADIW   = 5'd2,
        OP_SUB    = 5'd3,
        OP_SUBI   = 5'd4,
        OP_SBC    = 5'd5,
        OP_SBCI   = 5'd6,
        OP_SBIW   = 5'd7,
        OP_AND    = 5'd8,
        OP_ANDI   = 5'd9,
        OP_OR     = 5'd10,
        OP_ORI    = 5'd11,
        OP_EOR    = 5'd12,
        OP_COM    = 5'd13,
        OP_NEG    = 5'd14,
        OP_SBR    = 5'd15,
        OP_CBR    = 5'd16,
        OP_INC    = 5'd17,
        OP_DEC    = 5'd18,
        OP_TST    = 5'd19,
        OP_CLR    = 5'd20,
        OP_SER    = 5'd21,
        OP_MUL    = 5'd22,
        OP_MULS   = 5'd23,
        OP_MULSU  = 5'd24,
        OP_FMUL   = 5'd25,
        OP_FMULS  = 5'd26,
        OP_FMULSU = 5'd27
    } op_t;

    // status bits: H S V N Z C from high to low
    localparam logic [5:0] FLG_C = 6'b000001;
    localparam logic [5:0] FLG_Z = 6'b000010;
    localparam logic [5:0] FLG_N = 6'b000100;
    localparam logic [5:0] FLG_V = 6'b001000;
    localparam logic [5:0] FLG_S = 6'b010000;
    localparam logic [5:0] FLG_H = 6'b100000;

    typedef struct packed {
        logic [7:0] r;
        logic [5:0] f;
    } alu_res_t;

endpackage

@@ rtl/eight_bit_mcu_alu_regfile.sv @@
// ----------------------------------------------------------------------------
// eight_bit_mcu_alu_regfile
// Eight-bit MCU ALU executing one instruction per request against a
// 32 x 8 register file held in two banked memories, and a status register.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  input   | in_valid / in_stall   | operation, dest_index, source_index, immediate
//  output  | out_valid / out_stall | result_low, result_high, flags_out
//
//  One request per cycle sustained while out_stall is low; a result is
//  registered in the output register when its request leaves execute.
//  The rate is set by the register file read-modify-write loop: read at
//  accept, execute and write back at retire, closed by a one-deep bypass.
//  Reset clears per-entry valid bits at once; no clearing pass, unwritten
//  registers read as zero. A stalled output holds its register; one more
//  request may wait in the execute stage before in_stall rises.
// ----------------------------------------------------------------------------
module eight_bit_mcu_alu_regfile
    import mcualu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] operation,
    input  logic [4:0] dest_index,
    input  logic [4:0] source_index,
    input  logic [7:0] immediate,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result_low,
    output logic [7:0] result_high,
    output logic [5:0] flags_out
);

`include "eight_bit_mcu_alu_regfile_macros.svh"

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ONE,
        WR_PAIR,
        WR_MUL
    } wr_t;

    // banked register file: even and odd registers
    logic [7:0] mem_e [ROW_COUNT];
    logic [7:0] mem_o [ROW_COUNT];
    logic [ROW_COUNT-1:0] vld_e_reg;
    logic [ROW_COUNT-1:0] vld_o_reg;

    logic [5:0] flags_reg;

    // execute stage
    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic [REG_IDX_W-1:0] s1_addr_a_reg;
    logic [REG_IDX_W-1:0] s1_addr_b_reg;
    logic [7:0]           s1_k_reg;
    logic [7:0]           s1_rd_a_reg;
    logic [7:0]           s1_rd_b_reg;
    logic                 s1_va_reg;
    logic                 s1_vb_reg;
    logic                 s1_fwd_reg;

    // last write, for the bypass
    logic             bp_we_e_reg;
    logic             bp_we_o_reg;
    logic [ROW_W-1:0] bp_row_e_reg;
    logic [ROW_W-1:0] bp_row_o_reg;
    logic [7:0]       bp_dat_e_reg;
    logic [7:0]       bp_dat_o_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] res_lo_reg;
    logic [7:0] res_hi_reg;
    logic [5:0] res_flags_reg;

    logic                 s1_move;
    logic                 in_fire;
    logic                 wr_fire;
    op_t                  op_in;
    logic                 word_in;
    logic [REG_IDX_W-1:0] addr_a_in;
    logic [REG_IDX_W-1:0] addr_b_in;
    logic [ROW_W-1:0]     row_a_in;
    logic [ROW_W-1:0]     row_b_in;

    logic [7:0]  opa;
    logic [7:0]  opb;
    logic        hit_a_e;
    logic        hit_a_o;
    logic        hit_b_e;
    logic        hit_b_o;
    logic        cin;
    logic        x_signed;
    logic        y_signed;
    logic        frac;
    logic signed [8:0]  mx;
    logic signed [8:0]  my;
    logic signed [17:0] mp;
    logic [15:0] p16;
    logic [15:0] pf;
    logic [15:0] wval;
    logic [15:0] k6;
    logic [15:0] wres;
    alu_res_t    ar;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  tmp;
    logic [5:0]  mask;
    logic [5:0]  val;
    logic        set_s;
    wr_t         wr_mode;
    logic [5:0]  fm;
    logic [5:0]  new_flags;

    logic             we_e;
    logic             we_o;
    logic [ROW_W-1:0] row_e;
    logic [ROW_W-1:0] row_o;
    logic [7:0]       dat_e;
    logic [7:0]       dat_o;

    function automatic logic [5:0] nz8(input logic [7:0] r);
        return (r[7] ? FLG_N : 6'd0) | ((r == 8'd0) ? FLG_Z : 6'd0);
    endfunction

    function automatic alu_res_t add8(input logic [7:0] x, input logic [7:0] y,
                                      input logic ci);
        alu_res_t   o;
        logic [7:0] r;
        logic [7:0] cv;
        logic [7:0] ov;
        r = x + y + {7'd0, ci};
        cv = (x & y) | (y & ~r) | (~r & x);
        ov = (x & y & ~r) | (~x & ~y & r);
        o.r = r;
        o.f = nz8(r) | (cv[3] ? FLG_H : 6'd0) | (cv[7] ? FLG_C : 6'd0)
            | (ov[7] ? FLG_V : 6'd0);
        return o;
    endfunction

    function automatic alu_res_t sub8(input logic [7:0] x, input logic [7:0] y,
                                      input logic ci);
        alu_res_t   o;
        logic [7:0] r;
        logic [7:0] bv;
        logic [7:0] ov;
        r = x - y - {7'd0, ci};
        bv = (~x & y) | (y & r) | (r & ~x);
        ov = (x & ~y & ~r) | (~x & y & r);
        o.r = r;
        o.f = nz8(r) | (bv[3] ? FLG_H : 6'd0) | (bv[7] ? FLG_C : 6'd0)
            | (ov[7] ? FLG_V : 6'd0);
        return o;
    endfunction

    assign s1_move  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_fire  = in_valid && !in_stall;
    assign wr_fire  = s1_valid_reg && s1_move;

    // word ops read the register pair; others read Rd and Rr
    assign op_in     = op_t'(operation);
    assign word_in   = (op_in == OP_ADIW) || (op_in == OP_SBIW);
    assign addr_a_in = word_in ? {dest_index[REG_IDX_W-1:1], 1'b0}
                               : dest_index[REG_IDX_W-1:0];
    assign addr_b_in = word_in ? {dest_index[REG_IDX_W-1:1], 1'b1}
                               : source_index[REG_IDX_W-1:0];
    assign row_a_in  = addr_a_in[REG_IDX_W-1:1];
    assign row_b_in  = addr_b_in[REG_IDX_W-1:1];

    // bypass the write that landed at the edge this request was read
    assign hit_a_e = s1_fwd_reg && bp_we_e_reg && !s1_addr_a_reg[0]
                     && (bp_row_e_reg == s1_addr_a_reg[REG_IDX_W-1:1]);
    assign hit_a_o = s1_fwd_reg && bp_we_o_reg && s1_addr_a_reg[0]
                     && (bp_row_o_reg == s1_addr_a_reg[REG_IDX_W-1:1]);
    assign hit_b_e = s1_fwd_reg && bp_we_e_reg && !s1_addr_b_reg[0]
                     && (bp_row_e_reg == s1_addr_b_reg[REG_IDX_W-1:1]);
    assign hit_b_o = s1_fwd_reg && bp_we_o_reg && s1_addr_b_reg[0]
                     && (bp_row_o_reg == s1_addr_b_reg[REG_IDX_W-1:1]);

    always_comb
    begin
        priority if (hit_a_e)
            opa = bp_dat_e_reg;
        else if (hit_a_o)
            opa = bp_dat_o_reg;
        else
            opa = s1_va_reg ? s1_rd_a_reg : 8'd0;

        priority if (hit_b_e)
            opb = bp_dat_e_reg;
        else if (hit_b_o)
            opb = bp_dat_o_reg;
        else
            opb = s1_vb_reg ? s1_rd_b_reg : 8'd0;
    end

    // multiplier
    assign x_signed = (s1_op_reg == OP_MULS) || (s1_op_reg == OP_MULSU)
                      || (s1_op_reg == OP_FMULS) || (s1_op_reg == OP_FMULSU);
    assign y_signed = (s1_op_reg == OP_MULS) || (s1_op_reg == OP_FMULS);
    assign frac     = (s1_op_reg == OP_FMUL) || (s1_op_reg == OP_FMULS)
                      || (s1_op_reg == OP_FMULSU);
    assign mx  = $signed({x_signed & opa[7], opa});
    assign my  = $signed({y_signed & opb[7], opb});
    assign mp  = mx * my;
    assign p16 = mp[15:0];
    assign pf  = frac ? {p16[14:0], 1'b0} : p16;

    // word add and subtract on the pair
    assign wval = {opb, opa};
    assign k6   = {10'd0, s1_k_reg[5:0]};
    assign wres = (s1_op_reg == OP_ADIW) ? wval + k6 : wval - k6;

    assign cin = |(flags_reg & FLG_C);

    always_comb
    begin
        ar      = '0;
        tmp     = 8'd0;
        lo      = 8'd0;
        hi      = 8'd0;
        mask    = 6'd0;
        val     = 6'd0;
        set_s   = 1'b0;
        wr_mode = WR_ONE;
        unique case (s1_op_reg)
            OP_ADD, OP_ADC:
            begin
                ar    = add8(opa, opb, (s1_op_reg == OP_ADC) & cin);
                lo    = ar.r;
                mask  = FLG_H | FLG_V | FLG_N | FLG_Z | FLG_C;
                val   = ar.f;
                set_s = 1'b1;
            end
            OP_SUB, OP_SUBI, OP_SBC, OP_SBCI:
            begin
                ar = sub8(opa,
                          ((s1_op_reg == OP_SUBI) || (s1_op_reg == OP_SBCI)) ?
                              s1_k_reg : opb,
                          ((s1_op_reg == OP_SBC) || (s1_op_reg == OP_SBCI)) & cin);
                lo  = ar.r;
                val = ar.f;
                // carry forms keep Z only if it was already set
                if (((s1_op_reg == OP_SBC) || (s1_op_reg == OP_SBCI))
                    && !(|(flags_reg & FLG_Z)))
                    val = val & ~FLG_Z;
                mask  = FLG_H | FLG_V | FLG_N | FLG_Z | FLG_C;
                set_s = 1'b1;
            end
            OP_ADIW, OP_SBIW:
            begin
                lo = wres[7:0];
                hi = wres[15:8];
                if (s1_op_reg == OP_ADIW)
                    val = ((!opb[7] && wres[15]) ? FLG_V : 6'd0)
                        | ((!wres[15] && opb[7]) ? FLG_C : 6'd0);
                else
                    val = ((opb[7] && !wres[15]) ? FLG_V : 6'd0)
                        | ((wres[15] && !opb[7]) ? FLG_C : 6'd0);
                val = val | (wres[15] ? FLG_N : 6'd0)
                    | ((wres == 16'd0) ? FLG_Z : 6'd0);
                mask    = FLG_V | FLG_N | FLG_Z | FLG_C;
                set_s   = 1'b1;
                wr_mode = WR_PAIR;
            end
            OP_AND, OP_ANDI, OP_OR, OP_ORI, OP_EOR, OP_SBR, OP_CBR, OP_TST, OP_CLR:
            begin
                unique case (s1_op_reg)
                    OP_AND:  tmp = opa & opb;
                    OP_ANDI: tmp = opa & s1_k_reg;
                    OP_OR:   tmp = opa | opb;
                    OP_ORI:  tmp = opa | s1_k_reg;
                    OP_EOR:  tmp = opa ^ opb;
                    OP_SBR:  tmp = opa | s1_k_reg;
                    OP_CBR:  tmp = opa & ~s1_k_reg;
                    OP_TST:  tmp = opa;
                    default: tmp = 8'd0;
                endcase
                lo    = tmp;
                mask  = FLG_V | FLG_N | FLG_Z;
                val   = nz8(tmp);
                set_s = 1'b1;
            end
            OP_COM:
            begin
                lo    = ~opa;
                mask  = FLG_V | FLG_N | FLG_Z | FLG_C;
                val   = nz8(~opa) | FLG_C;
                set_s = 1'b1;
            end
            OP_NEG:
            begin
                tmp   = 8'd0 - opa;
                lo    = tmp;
                mask  = FLG_H | FLG_V | FLG_N | FLG_Z | FLG_C;
                val   = nz8(tmp) | ((tmp[3] | opa[3]) ? FLG_H : 6'd0)
                      | ((tmp == 8'h80) ? FLG_V : 6'd0)
                      | ((tmp != 8'd0) ? FLG_C : 6'd0);
                set_s = 1'b1;
            end
            OP_INC:
            begin
                tmp   = opa + 8'd1;
                lo    = tmp;
                mask  = FLG_V | FLG_N | FLG_Z;
                val   = nz8(tmp) | ((tmp == 8'h80) ? FLG_V : 6'd0);
                set_s = 1'b1;
            end
            OP_DEC:
            begin
                tmp   = opa - 8'd1;
                lo    = tmp;
                mask  = FLG_V | FLG_N | FLG_Z;
                val   = nz8(tmp) | ((tmp == 8'h7F) ? FLG_V : 6'd0);
                set_s = 1'b1;
            end
            OP_SER:
            begin
                lo = 8'hFF;
            end
            OP_MUL, OP_MULS, OP_MULSU, OP_FMUL, OP_FMULS, OP_FMULSU:
            begin
                lo      = pf[7:0];
                hi      = pf[15:8];
                mask    = FLG_Z | FLG_C;
                // C comes from the product before the fractional shift
                val     = (p16[15] ? FLG_C : 6'd0) | ((pf == 16'd0) ? FLG_Z : 6'd0);
                wr_mode = WR_MUL;
            end
            default:
            begin
                wr_mode = WR_NONE;
            end
        endcase
    end

    always_comb
    begin
        fm = (flags_reg & ~mask) | (val & mask);
        if (set_s)
            new_flags = (fm & ~FLG_S)
                      | (((|(fm & FLG_N)) ^ (|(fm & FLG_V))) ? FLG_S : 6'd0);
        else
            new_flags = fm;
    end

    // steer the write into the banks
    always_comb
    begin
        we_e  = 1'b0;
        we_o  = 1'b0;
        row_e = s1_addr_a_reg[REG_IDX_W-1:1];
        row_o = s1_addr_a_reg[REG_IDX_W-1:1];
        dat_e = lo;
        dat_o = lo;
        unique case (wr_mode)
            WR_ONE:
            begin
                we_e = wr_fire && !s1_addr_a_reg[0];
                we_o = wr_fire && s1_addr_a_reg[0];
            end
            WR_PAIR:
            begin
                we_e  = wr_fire;
                we_o  = wr_fire;
                dat_o = hi;
            end
            WR_MUL:
            begin
                we_e  = wr_fire;
                we_o  = wr_fire;
                row_e = '0;
                row_o = '0;
                dat_o = hi;
            end
            WR_NONE:
            begin
                we_e = 1'b0;
                we_o = 1'b0;
            end
        endcase
    end

    // register file banks: read at accept, write at retire
    always_ff @(posedge clk)
    begin
        if (we_e)
            mem_e[row_e] <= dat_e;
        if (we_o)
            mem_o[row_o] <= dat_o;
        if (in_fire)
        begin
            s1_rd_a_reg <= addr_a_in[0] ? mem_o[row_a_in] : mem_e[row_a_in];
            s1_rd_b_reg <= addr_b_in[0] ? mem_o[row_b_in] : mem_e[row_b_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg     <= '0;
            vld_o_reg     <= '0;
            flags_reg     <= 6'd0;
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            bp_we_e_reg   <= 1'b0;
            bp_we_o_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (we_e)
                vld_e_reg[row_e] <= 1'b1;
            if (we_o)
                vld_o_reg[row_o] <= 1'b1;
            if (wr_fire)
            begin
                flags_reg   <= new_flags;
                bp_we_e_reg <= we_e;
                bp_we_o_reg <= we_o;
            end
            if (in_fire)
                s1_fwd_reg <= wr_fire;
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (wr_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= op_in;
            s1_addr_a_reg <= addr_a_in;
            s1_addr_b_reg <= addr_b_in;
            s1_k_reg      <= immediate;
            s1_va_reg     <= addr_a_in[0] ? vld_o_reg[row_a_in] : vld_e_reg[row_a_in];
            s1_vb_reg     <= addr_b_in[0] ? vld_o_reg[row_b_in] : vld_e_reg[row_b_in];
        end
        if (wr_fire)
        begin
            bp_row_e_reg  <= row_e;
            bp_row_o_reg  <= row_o;
            bp_dat_e_reg  <= dat_e;
            bp_dat_o_reg  <= dat_o;
            res_lo_reg    <= lo;
            res_hi_reg    <= hi;
            res_flags_reg <= new_flags;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_low  = res_lo_reg;
    assign result_high = res_hi_reg;
    assign flags_out   = res_flags_reg;

    // both banks are written only by pair and multiply requests
    `MCU_ASSERT_NOW(a_dual_write, we_e && we_o, (wr_mode == WR_PAIR) || (wr_mode == WR_MUL))
    // writes happen only when a request retires into the output register
    `MCU_ASSERT_NEXT(a_write_retires, we_e || we_o, out_valid_reg)
    // an accepted request always reaches the execute stage
    `MCU_ASSERT_NEXT(a_accept_fills, in_fire, s1_valid_reg)
    // a waiting execute stage never writes the register file
    `MCU_ASSERT_NOW(a_hold_no_write, s1_valid_reg && !s1_move, !we_e && !we_o)

endmodule
